>>> src/shw_pkg.sv
// Package for the SHA-256 word hasher: payload types, item kinds, constants.
// Used by every module in src; depends on nothing.
`timescale 1ns / 1ps
package shw_pkg;
   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_FINISH = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] message_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] PAD_WORD = 32'h80000000;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage

>>> src/sha256_word_hasher.sv
// SHA-256 word hasher top level: front queue and compression back end.
// Depends on shw_pkg, shw_front, shw_back.
`timescale 1ns / 1ps
// Items are start, message word or finish. The sixteenth word of a block and a
// finish run the 64-round compression at one round per cycle, followed by the
// chaining add; a finish runs the compression twice when the padding spills
// into an extra block. A finish gives eight digest items, H0 first; the back
// end waits until all eight are popped. A short item queue lets the input side
// keep pushing while the back end is busy.
module sha256_word_hasher
   import shw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);
   logic    q_valid, q_take;
   req_type q_data;

   shw_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_push, .req_data, .req_full,
      .q_valid, .q_data, .q_take);

   shw_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_take,
      .rsp_empty, .rsp_data, .rsp_pop);
endmodule

>>> src/shw_front.sv
// Front end: accepts items, drops unused kinds, queues the rest.
// Depends on shw_pkg.
`timescale 1ns / 1ps
module shw_front
   import shw_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_take
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            keep;

   assign req_full = (cnt_ff == (AW+1)'(DEPTH));
   assign keep     = req_push && !req_full && (req_data.kind != KIND_NONE);
   assign q_valid  = (cnt_ff != '0);
   assign q_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (keep) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_take && q_valid) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(keep) - (AW+1)'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (keep) begin
         mem_ff[wr_ff] <= req_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !keep) else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |=> (cnt_ff <= 1)) else $error("count jumped");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      (q_take && !q_valid) |=> $stable(cnt_ff) || (cnt_ff == 1)) else $error("bad take");
endmodule

>>> src/shw_back.sv
// Back end: block buffer, message schedule and one-round-per-cycle compression,
// padding and digest output register. Depends on shw_pkg.
`timescale 1ns / 1ps
module shw_back
   import shw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  req_type q_data,
   output logic    q_take,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);
   typedef enum logic [2:0] {
      S_IDLE, S_ROUND, S_ADD, S_EMIT
   } state_type;

   state_type    state_ff;
   logic [31:0]  w_ff [16];
   logic [31:0]  v_ff [8];
   logic [31:0]  h_ff [8];
   logic [3:0]   pend_ff;
   logic [31:0]  bytes_ff;
   logic [5:0]   round_ff;
   logic         extra_ff;
   logic [2:0]   out_ff;
   logic         out_valid_ff;

   logic [31:0]  s0, s1, wnew, t1, t2, e, a;

   assign q_take    = (state_ff == S_IDLE) && q_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = '{digest_word: h_ff[out_ff], word_number: out_ff,
                        last_word: (out_ff == 3'd7)};

   always_comb begin
      s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      e    = v_ff[4];
      a    = v_ff[0];
      t1   = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_CONST[round_ff] + w_ff[0];
      t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= '0;
         bytes_ff     <= '0;
         extra_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
         round_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  unique case (kind_type'(q_data.kind))
                     KIND_START: begin
                        for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
                        pend_ff  <= '0;
                        bytes_ff <= '0;
                     end
                     KIND_WORD: begin
                        w_ff[pend_ff] <= q_data.message_word;
                        pend_ff  <= pend_ff + 1'b1;
                        bytes_ff <= bytes_ff + 32'd4;
                        if (pend_ff == 4'd15) begin
                           for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                           round_ff <= '0;
                           extra_ff <= 1'b0;
                           out_ff   <= '0;
                           state_ff <= S_ROUND;
                        end
                     end
                     KIND_FINISH: begin
                        for (int i = 0; i < 16; i++) begin
                           if (4'(i) == pend_ff) begin
                              w_ff[i] <= PAD_WORD;
                           end else if (i == 15 && pend_ff < 4'd14) begin
                              w_ff[i] <= {bytes_ff[28:0], 3'b000};
                           end else if (4'(i) > pend_ff) begin
                              w_ff[i] <= '0;
                           end
                        end
                        extra_ff <= (pend_ff >= 4'd14);
                        for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                        round_ff <= '0;
                        pend_ff  <= '0;
                        out_ff   <= 3'd1;
                        state_ff <= S_ROUND;
                     end
                     default: ;
                  endcase
               end
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 1'b1;
               if (round_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               round_ff <= '0;
               if (extra_ff) begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= '0;
                  w_ff[15] <= {bytes_ff[28:0], 3'b000};
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i] + v_ff[i];
                  extra_ff <= 1'b0;
                  state_ff <= S_ROUND;
               end else if (out_ff == 3'd1) begin
                  out_ff       <= '0;
                  out_valid_ff <= 1'b1;
                  state_ff     <= S_EMIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (rsp_pop) begin
                  if (out_ff == 3'd7) begin
                     out_valid_ff <= 1'b0;
                     out_ff       <= '0;
                     state_ff     <= S_IDLE;
                  end else begin
                     out_ff <= out_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == S_EMIT)) else $error("result outside emit");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      q_take |-> (state_ff == S_IDLE)) else $error("item taken while busy");
   a_round_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff != 6'd63) |=> (state_ff == S_ROUND))
      else $error("round run broken");
endmodule

>>> verif/tb_sha256_word_hasher.sv
// Testbench for sha256_word_hasher: directed and random start/word/finish items
// checked against a behavioural SHA-256 predictor. Depends on shw_pkg and the RTL.
`timescale 1ns / 1ps
module tb_sha256_word_hasher;
   import shw_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   logic    rsp_pop = 1'b0;

   sha256_word_hasher uut (.*);

   always #4 clock = ~clock;

   req_type     pending_items[$];
   rsp_type     digest_due[$];
   logic [31:0] blk[16];
   logic [31:0] chain[8];
   logic [3:0]  fill;
   logic [31:0] bytes_taken;
   int          failures = 0;
   int          idle_cycles = 0;
   bit          feeding_done = 0;
   bit          hold_off = 0;
   bit          in_taken = 0;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic predict_digest(req_type it);
      rsp_type r;
      case (kind_type'(it.kind))
         KIND_START: begin
            for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
            fill = 0;
            bytes_taken = 0;
         end
         KIND_WORD: begin
            blk[fill] = it.message_word;
            fill++;
            if (fill == 0) compress();
            bytes_taken += 4;
         end
         KIND_FINISH: begin
            for (int i = fill; i < 16; i++) blk[i] = '0;
            blk[fill] = PAD_WORD;
            if (fill >= 14) begin
               compress();
               for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            blk[15] = bytes_taken * 8;
            compress();
            fill = 0;
            for (int i = 0; i < 8; i++) begin
               r.digest_word = chain[i];
               r.word_number = i[2:0];
               r.last_word   = (i == 7);
               digest_due.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   function automatic req_type mk(kind_type k, logic [31:0] w);
      req_type it;
      it.kind = k;
      it.message_word = w;
      return it;
   endfunction

   initial begin
      int n;
      for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
      fill = 0;
      bytes_taken = 0;
      // directed: words before any start, empty message, unused kind, extremes
      pending_items.push_back(mk(KIND_WORD, 32'hffffffff));
      pending_items.push_back(mk(KIND_FINISH, 32'h0));
      pending_items.push_back(mk(KIND_START, 32'hffffffff));
      pending_items.push_back(mk(KIND_NONE, 32'h12345678));
      pending_items.push_back(mk(KIND_FINISH, 32'h0));
      pending_items.push_back(mk(KIND_START, 32'h0));
      for (int i = 0; i < 14; i++)
         pending_items.push_back(mk(KIND_WORD, (i % 2) ? 32'h0 : 32'hffffffff));
      pending_items.push_back(mk(KIND_FINISH, 32'h0));
      pending_items.push_back(mk(KIND_WORD, 32'h61626380));
      pending_items.push_back(mk(KIND_FINISH, 32'h0));
      // random messages, mostly well formed, lengths biased to block edges
      while (pending_items.size() < 170) begin
         if ($urandom_range(0, 9) != 0) pending_items.push_back(mk(KIND_START, $urandom));
         case ($urandom_range(0, 3))
            0: n = $urandom_range(0, 3);
            1: n = $urandom_range(13, 17);
            2: n = $urandom_range(29, 33);
            default: n = $urandom_range(0, 20);
         endcase
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
               pending_items.push_back(mk(KIND_NONE, $urandom));
            pending_items.push_back(mk(KIND_WORD, $urandom));
         end
         pending_items.push_back(mk(KIND_FINISH, $urandom));
      end
   end

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || in_taken) begin
         in_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
            feeding_done = 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_digest(req_data);
         in_taken = 1;
         send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
   end

   // monitor
   int pop_gap = 0;
   int hold_count = 0;
   always @(posedge clock) begin
      rsp_type exp_item;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (digest_due.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_data);
            failures++;
         end else begin
            exp_item = digest_due.pop_front();
            if (rsp_data.digest_word !== exp_item.digest_word)
               $display("%0t: digest_word exp %h got %h", $time,
                        exp_item.digest_word, rsp_data.digest_word);
            if (rsp_data.word_number !== exp_item.word_number)
               $display("%0t: word_number exp %0d got %0d", $time,
                        exp_item.word_number, rsp_data.word_number);
            if (rsp_data.last_word !== exp_item.last_word)
               $display("%0t: last_word exp %0d got %0d", $time,
                        exp_item.last_word, rsp_data.last_word);
            if (rsp_data !== exp_item) failures++;
         end
         pop_gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (!reset && ((rsp_pop && !rsp_empty) || (req_push && !req_full))) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_off) begin
         rsp_pop <= 1'b0;
         hold_count++;
         if (hold_count >= 600) hold_off = 0;
      end else if (rsp_pop && !rsp_empty) begin
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // long receiver stall early on, while the sender keeps pushing
      repeat (40) @(posedge clock);
      @(negedge clock);
      hold_count = 0;
      hold_off = 1;
   end

   initial begin
      wait (!reset);
      fork
         begin
            wait (feeding_done && !req_push && digest_due.size() == 0);
            repeat (200) @(posedge clock);
         end
         wait (idle_cycles >= 5000);
      join_any
      if (idle_cycles >= 5000 || digest_due.size() != 0) begin
         $display("Test completed with failures");
      end else if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

>>> files.f
src/shw_pkg.sv
src/shw_front.sv
src/shw_back.sv
src/sha256_word_hasher.sv
verif/tb_sha256_word_hasher.sv
